// ===== design/qmr_pkg.sv =====
`default_nettype none

package qmr_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Component width and the full width of one exact product.
  localparam int COMP_W = 32;
  localparam int QW_W   = COMP_W + 1;
  localparam int PROD_W = 2 * COMP_W;

  // Register stages inside one Hamilton product unit.
  localparam int HAM_STAGES = 4;

  // Component positions.
  localparam int CX = 0;
  localparam int CY = 1;
  localparam int CZ = 2;
  localparam int CW = 3;

  // Operation codes.
  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } op_t;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [QW_W-1:0]   qwide_t;

  localparam comp_t COMP_MAX = 32'sh7fffffff;
  localparam comp_t COMP_MIN = 32'sh80000000;

  // Data that travels beside the operands through a product unit.
  typedef struct packed {
    op_t                    op;
    logic [3:0][COMP_W-1:0] v;
    logic                   sat;
  } sb_t;

  // Hamilton product terms: component i is the signed sum over j of
  // p[P_IDX[j]] * q[Q_IDX[i][j]], negated where NEG[i][j] is set.
  localparam logic [1:0] P_IDX [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] Q_IDX [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [3:0] NEG [4] = '{4'b1000, 4'b0010, 4'b0100, 4'b1110};

endpackage

`default_nettype wire

// ===== design/qmr_if.sv =====
`default_nettype none

// Operand channel: one quaternion operation per transaction.
interface qmr_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] a_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] b_w;

  modport source (
    output valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    input  ready
  );
  modport sink (
    input  valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    output ready
  );
endinterface

// Result channel: one quaternion and a saturation flag per transaction.
interface qmr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_w;
  logic               saturated;

  modport source (
    output valid, r_x, r_y, r_z, r_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_w, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/qmr_ham.sv =====
`default_nettype none

// Four-stage pipelined Hamilton product p*q with truncating fixed-point
// scaling and saturation: multiply, scale, sum, clamp.
module qmr_ham #(
  parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qmr_pkg::comp_t  p [4],
  input  wire qmr_pkg::qwide_t q [4],
  input  wire qmr_pkg::sb_t  sb_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qmr_pkg::comp_t     r [4],
  output logic [3:0]         sat,
  output qmr_pkg::sb_t       sb_out
);
  import qmr_pkg::*;

  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;

  // Exact product scaled down, rounding toward zero.
  function automatic logic signed [TERM_W-1:0] trunc_term(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] adj;
    adj = prod + PROD_W'({FRAC_BITS{prod[PROD_W-1]}});
    return TERM_W'(adj >>> FRAC_BITS);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic signed [PROD_W-1:0] prod1_r [4][4];
  logic signed [PROD_W-1:0] prod1_nxt [4][4];
  logic signed [TERM_W-1:0] term2_r [4][4];
  logic signed [TERM_W-1:0] term2_nxt [4][4];
  logic signed [SUM_W-1:0]  sum3_r [4];
  logic signed [SUM_W-1:0]  sum3_nxt [4];
  comp_t                    r4_r [4];
  comp_t                    r4_nxt [4];
  logic [3:0]               sat4_r, sat4_nxt;
  sb_t                      sb1_r, sb2_r, sb3_r, sb4_r;

  // Each stage advances when it is empty or the next one advances.
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: sixteen exact products.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod1_nxt[i][j] = PROD_W'(p[P_IDX[j]]) * PROD_W'(q[Q_IDX[i][j]]);
      end
    end
  end

  // Stage 2: scale each product.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        term2_nxt[i][j] = trunc_term(prod1_r[i][j]);
      end
    end
  end

  // Stage 3: signed sum of the four terms of each component.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum3_nxt[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (NEG[i][j]) begin
          sum3_nxt[i] = sum3_nxt[i] - SUM_W'(term2_r[i][j]);
        end else begin
          sum3_nxt[i] = sum3_nxt[i] + SUM_W'(term2_r[i][j]);
        end
      end
    end
  end

  // Stage 4: clamp to the component range.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sum3_r[i] > SUM_W'(COMP_MAX)) begin
        r4_nxt[i]   = COMP_MAX;
        sat4_nxt[i] = 1'b1;
      end else if (sum3_r[i] < SUM_W'(COMP_MIN)) begin
        r4_nxt[i]   = COMP_MIN;
        sat4_nxt[i] = 1'b1;
      end else begin
        r4_nxt[i]   = COMP_W'(sum3_r[i]);
        sat4_nxt[i] = 1'b0;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      prod1_r <= prod1_nxt;
      sb1_r   <= sb_in;
    end
    if (en2) begin
      term2_r <= term2_nxt;
      sb2_r   <= sb1_r;
    end
    if (en3) begin
      sum3_r <= sum3_nxt;
      sb3_r  <= sb2_r;
    end
    if (en4) begin
      r4_r   <= r4_nxt;
      sat4_r <= sat4_nxt;
      sb4_r  <= sb3_r;
    end
  end

  assign out_valid = v4_r;
  assign r         = r4_r;
  assign sat       = sat4_r;
  assign sb_out    = sb4_r;

endmodule

`default_nettype wire

// ===== design/quaternion_multiply_rotate.sv =====
`default_nettype none

// Quaternion unit in signed fixed point (Q16.16 by default). One transaction
// in gives one transaction out, in order. The unit accepts a new operation
// every clock cycle unless backpressure has filled the stages. The path
// holds nine register stages: two four-stage Hamilton product pipelines
// (multiply, scale, sum, clamp) in series, then the output register. Both
// operations take the same path and the same time. A product's result is
// formed by the first unit and carried beside the second. A rotation uses
// the second unit to multiply by the conjugate.
// Backpressure on the result channel stalls only the stages that are full.
module quaternion_multiply_rotate #(
  parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qmr_in_if.sink     in_ch,
  qmr_out_if.source  out_ch
);
  import qmr_pkg::*;

  comp_t  p1 [4];
  qwide_t q1 [4];
  sb_t    sb1_in;
  logic   h1_out_valid, h1_out_ready;
  comp_t  t [4];
  logic [3:0] sat1;
  sb_t    sb1_out;

  qwide_t q2 [4];
  sb_t    sb2_in;
  logic   h2_out_valid, h2_out_ready;
  comp_t  r2 [4];
  logic [3:0] sat2;
  sb_t    sb2_out;

  logic   out_valid_r;
  comp_t  out_r_r [4];
  comp_t  out_r_nxt [4];
  logic   out_sat_r, out_sat_nxt;
  logic   out_en;

  // First product: a*b, with the scalar of b dropped for a rotation.
  assign p1[CX] = in_ch.a_x;
  assign p1[CY] = in_ch.a_y;
  assign p1[CZ] = in_ch.a_z;
  assign p1[CW] = in_ch.a_w;
  assign q1[CX] = QW_W'(in_ch.b_x);
  assign q1[CY] = QW_W'(in_ch.b_y);
  assign q1[CZ] = QW_W'(in_ch.b_z);
  assign q1[CW] = (op_t'(in_ch.op) == OP_ROTATE) ? '0 : QW_W'(in_ch.b_w);

  always_comb begin
    sb1_in.op  = op_t'(in_ch.op);
    sb1_in.v   = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
    sb1_in.sat = 1'b0;
  end

  qmr_ham #(.FRAC_BITS(FRAC_BITS)) u_ham1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .p         (p1),
    .q         (q1),
    .sb_in     (sb1_in),
    .out_valid (h1_out_valid),
    .out_ready (h1_out_ready),
    .r         (t),
    .sat       (sat1),
    .sb_out    (sb1_out)
  );

  // Second product: t*conj(a), negated at full width so nothing wraps.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q2[i] = -QW_W'($signed(sb1_out.v[i]));
    end
    q2[CW]     = QW_W'($signed(sb1_out.v[CW]));
    sb2_in.op  = sb1_out.op;
    sb2_in.v   = {t[CW], t[CZ], t[CY], t[CX]};
    sb2_in.sat = |sat1;
  end

  qmr_ham #(.FRAC_BITS(FRAC_BITS)) u_ham2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h1_out_valid),
    .in_ready  (h1_out_ready),
    .p         (t),
    .q         (q2),
    .sb_in     (sb2_in),
    .out_valid (h2_out_valid),
    .out_ready (h2_out_ready),
    .r         (r2),
    .sat       (sat2),
    .sb_out    (sb2_out)
  );

  // Result selection: the first product, or the rotated vector part.
  always_comb begin
    if (sb2_out.op == OP_ROTATE) begin
      out_r_nxt[CX] = r2[CX];
      out_r_nxt[CY] = r2[CY];
      out_r_nxt[CZ] = r2[CZ];
      out_r_nxt[CW] = '0;
      out_sat_nxt   = sb2_out.sat | (|sat2[CZ:CX]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        out_r_nxt[i] = $signed(sb2_out.v[i]);
      end
      out_sat_nxt = sb2_out.sat;
    end
  end

  // Output register.
  assign out_en       = !out_valid_r || out_ch.ready;
  assign h2_out_ready = out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= h2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r_r   <= out_r_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.r_x       = out_r_r[CX];
  assign out_ch.r_y       = out_r_r[CY];
  assign out_ch.r_z       = out_r_r[CZ];
  assign out_ch.r_w       = out_r_r[CW];
  assign out_ch.saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== design/qmr_chk.sv =====
`default_nettype none

// Port-level checks of the quaternion unit.
module qmr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] r_x,
  input wire logic [31:0] r_y,
  input wire logic [31:0] r_z,
  input wire logic [31:0] r_w,
  input wire logic        saturated
);
  import qmr_pkg::*;

  localparam int DEPTH = 2 * HAM_STAGES + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Transactions accepted but not yet delivered.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire && !out_fire) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_fire && !in_fire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(r_x) && $stable(r_y)
      && $stable(r_z) && $stable(r_w) && $stable(saturated))
    else $error("result changed while stalled");

  // With the output register empty, every stage can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  // The pipeline never holds more than its depth.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("more transactions in flight than stages");

  // No result without an accepted operation behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result offered with nothing in flight");

endmodule

bind quaternion_multiply_rotate qmr_chk u_qmr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .r_x       (out_ch.r_x),
  .r_y       (out_ch.r_y),
  .r_z       (out_ch.r_z),
  .r_w       (out_ch.r_w),
  .saturated (out_ch.saturated)
);

`default_nettype wire
